// ===== design/hpn_pkg.sv =====
// ----------------------------------------------------------------------------
// hpn_pkg: shared types and constants for the CRC-32 path hash unit
// Holds the byte table of the reflected CRC-32 and the item type that passes
// from the input stage to the CRC core.
// ----------------------------------------------------------------------------
`default_nettype none

package hpn_pkg;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // Path normalization codes
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;
   localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;
   localparam logic [7:0] CHAR_NUL      = 8'h00;

   typedef logic [31:0] crc_table_type [256];

   // Item held in the input register, already normalized
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       hash;   // fold data into the register
      logic       done;   // emit the register and restart
   } hpn_item_type;

   // Build the byte table at elaboration
   function automatic crc_table_type crc_table_gen();
      crc_table_type tbl;
      logic [31:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
         end
         tbl[i] = c;
      end
      return tbl;
   endfunction

   localparam crc_table_type CRC_TABLE = crc_table_gen();

endpackage

`default_nettype wire

// ===== design/crc32_hash_with_path_normalise_unit.sv =====
// ----------------------------------------------------------------------------
// crc32_hash_with_path_normalise_unit: streaming CRC-32 hash of byte messages
// Reflected CRC-32 (poly 0xEDB88320, init all ones, no final inversion) with
// optional path normalization and zero-byte termination.
// ----------------------------------------------------------------------------
// Takes one item per cycle while no ending item waits for a free result
// register: the byte-table lookup and xor that update the CRC register lie
// on the path from the input register to the CRC register, so items follow
// back to back. The result register captures the result from the item that
// ends its message and holds it while rsp_stall is high; a new ending item
// then waits in the input register. No clearing pass is needed after reset.
`default_nettype none

module crc32_hash_with_path_normalise_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_hash_value
);
   import hpn_pkg::*;

   logic         path_mode_ff;
   logic         advance;
   hpn_item_type item;

   // path mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         path_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         path_mode_ff <= csr_write_data;
      end
   end

   hpn_in_stage u_in_stage (
      .clock              (clock),
      .reset              (reset),
      .path_mode          (path_mode_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .advance            (advance),
      .item               (item)
   );

   hpn_crc_core u_crc_core (
      .clock          (clock),
      .reset          (reset),
      .item           (item),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

// ===== design/hpn_in_stage.sv =====
// ----------------------------------------------------------------------------
// hpn_in_stage: input register with path normalization
// Accepts request items, folds case and slashes in path mode and decides
// whether the item is hashed and whether it closes the message.
// ----------------------------------------------------------------------------
`default_nettype none

module hpn_in_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 path_mode,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_has_byte,
   input  wire logic                 req_end_of_message,
   input  wire logic                 advance,
   output hpn_pkg::hpn_item_type     item
);
   import hpn_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff,  data_in;
   logic       hash_ff,  hash_in;
   logic       done_ff,  done_in;
   logic       load;
   logic       nul_end;

   // hold the item while the core cannot take it
   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;

   // normalize the incoming byte
   always_comb begin
      data_in = req_data_byte;
      if (path_mode) begin
         if (req_data_byte >= CHAR_LOWER_A && req_data_byte <= CHAR_LOWER_Z) begin
            data_in = req_data_byte - CASE_OFFSET;
         end else if (req_data_byte == CHAR_BSLASH) begin
            data_in = CHAR_SLASH;
         end
      end
      nul_end  = path_mode & req_has_byte & (req_data_byte == CHAR_NUL);
      hash_in  = req_has_byte & ~nul_end;
      done_in  = req_end_of_message | nul_end;
      valid_in = req_stall ? valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload loads only on accept
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         hash_ff <= hash_in;
         done_ff <= done_in;
      end
   end

   assign item = '{valid: valid_ff, data: data_ff, hash: hash_ff, done: done_ff};

endmodule

`default_nettype wire

// ===== design/hpn_crc_core.sv =====
// ----------------------------------------------------------------------------
// hpn_crc_core: CRC register update and result register
// Folds one byte per cycle while items advance, via the byte table, and
// loads the raw CRC register into the result register when a message ends.
// ----------------------------------------------------------------------------
`default_nettype none

module hpn_crc_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hpn_pkg::hpn_item_type item,
   output logic                      advance,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [31:0]               rsp_hash_value
);
   import hpn_pkg::*;

   logic [31:0] crc_ff,  crc_in;
   logic [31:0] hash_ff;
   logic        rvalid_ff, rvalid_in;
   logic [31:0] crc_next;
   logic [7:0]  tbl_idx;

   // an ending item needs a free result register
   assign advance = item.valid & (~item.done | ~rvalid_ff | ~rsp_stall);

   // one table lookup and xor per byte
   always_comb begin
      tbl_idx  = crc_ff[7:0] ^ item.data;
      crc_next = item.hash ? (CRC_TABLE[tbl_idx] ^ (crc_ff >> 8)) : crc_ff;
      crc_in   = crc_ff;
      if (advance) begin
         crc_in = item.done ? CRC_INIT : crc_next;
      end
      rvalid_in = rvalid_ff & rsp_stall;
      if (advance & item.done) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         rvalid_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // capture the result on message end
   always_ff @(posedge clock) begin
      if (advance & item.done) begin
         hash_ff <= crc_next;
      end
   end

   assign rsp_valid      = rvalid_ff;
   assign rsp_hash_value = hash_ff;

`ifndef SYNTHESIS
   a_end_loads_result: assert property (@(posedge clock) disable iff (reset)
      (advance && item.done) |=> rsp_valid)
      else $error("message end did not produce a result");

   a_end_restarts_crc: assert property (@(posedge clock) disable iff (reset)
      (advance && item.done) |=> (crc_ff == CRC_INIT))
      else $error("CRC register not restarted after message end");

   a_crc_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (crc_ff == $past(crc_ff)))
      else $error("CRC register changed without an item");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && rsp_stall) |-> !(advance && item.done))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
